### hw/rtl/wps_pkg.sv
package wps_pkg;

    localparam int COORD_W     = 24;
    localparam int YAW_W       = 16;
    localparam int MARGIN_XY_W = 23;
    localparam int MARGIN_YAW_W = 15;
    localparam int WAIT_W      = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 23;

    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_X   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_Y   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_YAW = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GOAL_YAW   = 2'd3;

    localparam logic [MARGIN_XY_W-1:0]  MARGIN_X_RESET   = 23'd50;
    localparam logic [MARGIN_XY_W-1:0]  MARGIN_Y_RESET   = 23'd50;
    localparam logic [MARGIN_YAW_W-1:0] MARGIN_YAW_RESET = 15'd182;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_POSE = 1'b1;

    // CORDIC datapath: differences are 25 bits, scaled by 16 and grown by the gain.
    localparam int DIFF_W           = 25;
    localparam int CORDIC_W         = 32;
    localparam int ANGLE_ACC_W      = 20;
    localparam int CORDIC_MAX_STEPS = 24;
    localparam int STEP_W           = 5;

    typedef struct packed {
        logic                    mode;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] pose_x;
        logic signed [COORD_W-1:0] pose_y;
        logic signed [YAW_W-1:0]   pose_yaw;
    } wps_in_t;

    typedef struct packed {
        logic                      reached;
        logic                      stop_robot;
        logic                      new_target;
        logic signed [COORD_W-1:0] target_x;
        logic signed [COORD_W-1:0] target_y;
        logic signed [YAW_W-1:0]   target_yaw;
        logic                      load_refused;
        logic [WAIT_W-1:0]         points_waiting;
    } wps_out_t;

    typedef struct packed {
        logic capture;
        logic rd_en;
        logic rd_next;
        logic latch_first;
        logic cordic_init;
        logic cordic_step;
        logic commit;
    } wps_cmd_t;

    typedef struct packed {
        logic is_pose;
        logic reached;
        logic avail1;
        logic avail2;
        logic cordic_last;
    } wps_status_t;

    // Arctangent of 2^-i in 1/16 binary-angle units.
    function automatic logic [17:0] atan_entry(input logic [STEP_W-1:0] idx);
        logic [17:0] val;
        begin
            case (idx)
                5'd0:    val = 18'd131072;
                5'd1:    val = 18'd77376;
                5'd2:    val = 18'd40884;
                5'd3:    val = 18'd20753;
                5'd4:    val = 18'd10417;
                5'd5:    val = 18'd5213;
                5'd6:    val = 18'd2607;
                5'd7:    val = 18'd1304;
                5'd8:    val = 18'd652;
                5'd9:    val = 18'd326;
                5'd10:   val = 18'd163;
                5'd11:   val = 18'd81;
                5'd12:   val = 18'd41;
                5'd13:   val = 18'd20;
                5'd14:   val = 18'd10;
                5'd15:   val = 18'd5;
                5'd16:   val = 18'd3;
                5'd17:   val = 18'd1;
                5'd18:   val = 18'd1;
                default: val = 18'd0;
            endcase
            return val;
        end
    endfunction

endpackage

### hw/rtl/wps_ram.sv
module wps_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/wps_cordic.sv
module wps_cordic #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                    aclk,
    input  logic                                    init,
    input  logic                                    step,
    input  logic signed [wps_pkg::DIFF_W-1:0]       dx,
    input  logic signed [wps_pkg::DIFF_W-1:0]       dy,
    output logic                                    last,
    output logic signed [wps_pkg::YAW_W-1:0]        angle
);

    localparam int NUM_STEPS = (CORDIC_STEPS > wps_pkg::CORDIC_MAX_STEPS) ?
                               wps_pkg::CORDIC_MAX_STEPS : CORDIC_STEPS;
    localparam int CW = wps_pkg::CORDIC_W;
    localparam int ZW = wps_pkg::ANGLE_ACC_W;

    logic signed [CW-1:0]           x_reg, y_reg, x_next, y_next;
    logic signed [CW-1:0]           x0, y0, x_sh, y_sh;
    logic [ZW-1:0]                  z_reg, z_next, z_step, z_round;
    logic [wps_pkg::STEP_W-1:0]     idx_reg;
    logic                           zero_reg;

    // Scale by 16 so the low iterations keep fractional bits.
    assign x0 = {{(CW - wps_pkg::DIFF_W - 4){dx[wps_pkg::DIFF_W-1]}}, dx, 4'b0000};
    assign y0 = {{(CW - wps_pkg::DIFF_W - 4){dy[wps_pkg::DIFF_W-1]}}, dy, 4'b0000};

    assign x_sh   = x_reg >>> idx_reg;
    assign y_sh   = y_reg >>> idx_reg;
    assign z_step = {{(ZW - 18){1'b0}}, wps_pkg::atan_entry(idx_reg)};

    always_comb begin
        if (y_reg > $signed({CW{1'b0}})) begin
            x_next = x_reg + y_sh;
            y_next = y_reg - x_sh;
            z_next = z_reg + z_step;
        end else begin
            x_next = x_reg - y_sh;
            y_next = y_reg + x_sh;
            z_next = z_reg - z_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (init) begin
            idx_reg  <= '0;
            zero_reg <= (dx == '0) && (dy == '0);
            if (dx[wps_pkg::DIFF_W-1]) begin
                // Left half plane: rotate by pi first.
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= {1'b1, {(ZW - 1){1'b0}}};
            end else begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end else if (step) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    assign last    = (idx_reg == wps_pkg::STEP_W'(NUM_STEPS - 1));
    assign z_round = z_reg + ZW'(8);
    assign angle   = zero_reg ? '0 : z_round[ZW-1:4];

endmodule

### hw/rtl/wps_dp.sv
module wps_dp #(
    parameter int PATH_DEPTH   = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  wps_pkg::wps_in_t                     s_data,
    input  wps_pkg::wps_cmd_t                    cmd,
    output wps_pkg::wps_status_t                 status,
    output wps_pkg::wps_out_t                    m_data
);

    localparam int PTR_W = $clog2(PATH_DEPTH);
    localparam int CNT_W = $clog2(PATH_DEPTH + 1);
    localparam int CW    = wps_pkg::COORD_W;
    localparam int YW    = wps_pkg::YAW_W;

    wps_pkg::wps_in_t                      item_reg;
    wps_pkg::wps_out_t                     out_reg, out_next;
    logic [wps_pkg::MARGIN_XY_W-1:0]       margin_x_reg, margin_y_reg;
    logic [wps_pkg::MARGIN_YAW_W-1:0]      margin_yaw_reg;
    logic signed [YW-1:0]                  goal_yaw_reg;
    logic [PTR_W-1:0]                      rd_ptr_reg, rd_ptr_next, wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]                      rd_ptr_inc, rd_addr;
    logic [CNT_W-1:0]                      count_reg, count_next;
    logic signed [CW-1:0]                  wp_x_reg, wp_x_next, wp_y_reg, wp_y_next;
    logic signed [YW-1:0]                  wp_yaw_reg, wp_yaw_next;
    logic signed [CW-1:0]                  first_x_reg, first_y_reg;
    logic [2*CW-1:0]                       ram_rdata;
    logic signed [CW-1:0]                  rd_x, rd_y;
    logic signed [wps_pkg::DIFF_W-1:0]     dx, dy;
    logic signed [YW-1:0]                  cordic_angle;
    logic                                  cordic_last;
    logic signed [CW+1:0]                  vx, lox, hix, vy, loy, hiy;
    logic signed [YW+1:0]                  vw, low, hiw;
    logic                                  reached, full, avail1, avail2;
    logic                                  is_pose, do_write, do_pop;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(PATH_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Arrival windows, all open on both sides.
    always_comb begin
        vx  = {{2{item_reg.pose_x[CW-1]}}, item_reg.pose_x};
        lox = {{2{wp_x_reg[CW-1]}}, wp_x_reg} - {3'b000, margin_x_reg};
        hix = {{2{wp_x_reg[CW-1]}}, wp_x_reg} + {3'b000, margin_x_reg};
        vy  = {{2{item_reg.pose_y[CW-1]}}, item_reg.pose_y};
        loy = {{2{wp_y_reg[CW-1]}}, wp_y_reg} - {3'b000, margin_y_reg};
        hiy = {{2{wp_y_reg[CW-1]}}, wp_y_reg} + {3'b000, margin_y_reg};
        vw  = {{2{item_reg.pose_yaw[YW-1]}}, item_reg.pose_yaw};
        low = {{2{wp_yaw_reg[YW-1]}}, wp_yaw_reg} - {3'b000, margin_yaw_reg};
        hiw = {{2{wp_yaw_reg[YW-1]}}, wp_yaw_reg} + {3'b000, margin_yaw_reg};
        reached = (lox < vx) && (vx < hix) && (loy < vy) && (vy < hiy) &&
                  (low < vw) && (vw < hiw);
    end

    assign is_pose = (item_reg.mode == wps_pkg::MODE_POSE);
    assign full    = (count_reg == CNT_W'(PATH_DEPTH));
    assign avail1  = (count_reg != '0);
    assign avail2  = (count_reg > CNT_W'(1));

    assign status.is_pose     = is_pose;
    assign status.reached     = reached;
    assign status.avail1      = avail1;
    assign status.avail2      = avail2;
    assign status.cordic_last = cordic_last;

    assign rd_ptr_inc = ptr_inc(rd_ptr_reg);
    assign rd_addr    = cmd.rd_next ? rd_ptr_inc : rd_ptr_reg;
    assign do_write   = cmd.commit && !is_pose && !full;
    assign do_pop     = is_pose && reached && avail1;

    wps_ram #(
        .WIDTH (2 * CW),
        .DEPTH (PATH_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (do_write),
        .waddr (wr_ptr_reg),
        .wdata ({item_reg.point_x, item_reg.point_y}),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[2*CW-1:CW];
    assign rd_y = ram_rdata[CW-1:0];
    assign dx   = {rd_x[CW-1], rd_x} - {first_x_reg[CW-1], first_x_reg};
    assign dy   = {rd_y[CW-1], rd_y} - {first_y_reg[CW-1], first_y_reg};

    wps_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk  (aclk),
        .init  (cmd.cordic_init),
        .step  (cmd.cordic_step),
        .dx    (dx),
        .dy    (dy),
        .last  (cordic_last),
        .angle (cordic_angle)
    );

    // State after this item, and the result beat built from it.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        wp_x_next   = wp_x_reg;
        wp_y_next   = wp_y_reg;
        wp_yaw_next = wp_yaw_reg;
        if (!is_pose && !full) begin
            wr_ptr_next = ptr_inc(wr_ptr_reg);
            count_next  = count_reg + 1'b1;
        end else if (do_pop) begin
            rd_ptr_next = rd_ptr_inc;
            count_next  = count_reg - 1'b1;
            wp_x_next   = first_x_reg;
            wp_y_next   = first_y_reg;
            wp_yaw_next = avail2 ? cordic_angle : goal_yaw_reg;
        end
        out_next.reached        = is_pose && reached;
        out_next.stop_robot     = is_pose && reached;
        out_next.new_target     = do_pop;
        out_next.target_x       = wp_x_next;
        out_next.target_y       = wp_y_next;
        out_next.target_yaw     = wp_yaw_next;
        out_next.load_refused   = !is_pose && full;
        out_next.points_waiting = wps_pkg::WAIT_W'(count_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            margin_x_reg   <= wps_pkg::MARGIN_X_RESET;
            margin_y_reg   <= wps_pkg::MARGIN_Y_RESET;
            margin_yaw_reg <= wps_pkg::MARGIN_YAW_RESET;
            goal_yaw_reg   <= '0;
            rd_ptr_reg     <= '0;
            wr_ptr_reg     <= '0;
            count_reg      <= '0;
            wp_x_reg       <= '0;
            wp_y_reg       <= '0;
            wp_yaw_reg     <= '0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    wps_pkg::CFG_MARGIN_X: begin
                        margin_x_reg <= cfg_wdata;
                    end
                    wps_pkg::CFG_MARGIN_Y: begin
                        margin_y_reg <= cfg_wdata;
                    end
                    wps_pkg::CFG_MARGIN_YAW: begin
                        margin_yaw_reg <= cfg_wdata[wps_pkg::MARGIN_YAW_W-1:0];
                    end
                    wps_pkg::CFG_GOAL_YAW: begin
                        goal_yaw_reg <= cfg_wdata[YW-1:0];
                    end
                endcase
            end
            if (cmd.commit) begin
                rd_ptr_reg <= rd_ptr_next;
                wr_ptr_reg <= wr_ptr_next;
                count_reg  <= count_next;
                wp_x_reg   <= wp_x_next;
                wp_y_reg   <= wp_y_next;
                wp_yaw_reg <= wp_yaw_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg <= s_data;
        end
        if (cmd.latch_first) begin
            first_x_reg <= rd_x;
            first_y_reg <= rd_y;
        end
        if (cmd.commit) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

### hw/rtl/wps_ctrl.sv
module wps_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  wps_pkg::wps_status_t  status,
    output wps_pkg::wps_cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_RD_FIRST,
        ST_RD_SECOND,
        ST_CORDIC_INIT,
        ST_ITER,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.is_pose && status.reached && status.avail1) begin
                    state_next = ST_RD_FIRST;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_RD_FIRST: begin
                state_next = ST_RD_SECOND;
            end
            ST_RD_SECOND: begin
                state_next = status.avail2 ? ST_CORDIC_INIT : ST_FINISH;
            end
            ST_CORDIC_INIT: begin
                state_next = ST_ITER;
            end
            ST_ITER: begin
                if (status.cordic_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        cmd.capture     = (state_reg == ST_IDLE) && s_valid;
        cmd.rd_en       = (state_reg == ST_RD_FIRST) || (state_reg == ST_RD_SECOND);
        cmd.rd_next     = (state_reg == ST_RD_SECOND);
        cmd.latch_first = (state_reg == ST_RD_SECOND);
        cmd.cordic_init = (state_reg == ST_CORDIC_INIT);
        cmd.cordic_step = (state_reg == ST_ITER);
        cmd.commit      = (state_reg == ST_FINISH) && out_free;
    end

    always_comb begin
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

### hw/rtl/waypoint_sequencer_unit.sv
// Sequence: a load or a pose beat that issues no new waypoint goes from decode to the commit.
// A pose beat that pops a waypoint first reads the point store twice; when a second point is
// queued it then runs CORDIC_STEPS steps (capped at 24), since the heading comes from an
// iterative CORDIC that retires one step per cycle. A held result adds its m_ready stall.
// Flow: one beat at a time; the next beat is accepted the cycle after the result is
// registered, while the result waits on m_ready.
// Reset (aresetn low, synchronous) empties the point store and sets waypoint and margins.
module waypoint_sequencer_unit #(
    parameter int PATH_DEPTH   = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [wps_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [wps_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  wps_pkg::wps_in_t                s_data,
    output logic                            m_valid,
    input  logic                            m_ready,
    output wps_pkg::wps_out_t               m_data
);

    // The controller sequences each beat: capture, window test, two reads of the point
    // store (the popped point and the one behind it), the CORDIC iterations, and finally
    // the commit that updates the queue and waypoint and loads the result register.
    wps_pkg::wps_cmd_t    cmd;
    wps_pkg::wps_status_t status;

    // The controller owns the handshakes; it commits only when the result register
    // is empty or being drained in the same cycle.
    wps_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // The datapath holds the configuration, the point queue in a RAM, the current
    // waypoint, the window comparators and the heading CORDIC.
    wps_dp #(
        .PATH_DEPTH   (PATH_DEPTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .status    (status),
        .m_data    (m_data)
    );

endmodule
